[design/kfe_pkg.sv]
`timescale 1ns / 1ps

package kfe_pkg;

  // Table size and derived widths.
  localparam int MAX_KEYS  = 16;
  localparam int KEY_IDX_W = $clog2(MAX_KEYS);
  localparam int COUNT_W   = $clog2(MAX_KEYS + 1);

  // Working width for times, spans and wrapped times.
  localparam int WIDE_W = 36;

  // Sequential multiplier: 4-bit digits of the multiplier operand per cycle.
  localparam int MUL_A_W      = 52;
  localparam int MUL_B_W      = 36;
  localparam int MUL_P_W      = 88;
  localparam int MUL_DIGIT_W  = 4;
  localparam int MUL_DIGITS   = MUL_B_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W    = $clog2(MUL_DIGITS);

  // Restoring divider: one quotient bit per cycle.
  localparam int DIV_W     = 34;
  localparam int REM_W     = 35;
  localparam int DIV_CNT_W = 6;
  localparam int T_BITS    = 16;
  localparam int T_W       = 17;

  localparam logic [T_W-1:0] T_ONE    = 17'd65536;
  localparam logic [15:0]    SCALE_ONE = 16'd32768;

  localparam logic signed [MUL_P_W-1:0] HALF_Q16 = 88'sd32768;
  localparam logic signed [MUL_P_W-1:0] HALF_Q31 = 88'sd1073741824;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    WRAP_CLAMP = 2'd0,
    WRAP_LOOP  = 2'd1,
    WRAP_PING  = 2'd2,
    WRAP_RSVD  = 2'd3
  } kfe_wrap_t;

  typedef enum logic [1:0] {
    INTERP_STEP    = 2'd0,
    INTERP_LINEAR  = 2'd1,
    INTERP_HERMITE = 2'd2,
    INTERP_RSVD    = 2'd3
  } kfe_interp_t;

  typedef enum logic [1:0] {
    REG_WRAP_MODE   = 2'd0,
    REG_INTERP_MODE = 2'd1,
    REG_KEY_COUNT   = 2'd2,
    REG_NONE        = 2'd3
  } kfe_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD0,
    ST_RDL,
    ST_RDE,
    ST_WRAP,
    ST_MOD,
    ST_CMP,
    ST_SRD,
    ST_SCHK,
    ST_TDIV,
    ST_LIN,
    ST_T2,
    ST_T3,
    ST_P0,
    ST_M0,
    ST_P1,
    ST_M1,
    ST_S0,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_FIN
  } kfe_state_t;

  typedef struct packed {
    logic signed [31:0] key_time;
    logic signed [31:0] key_value;
    logic signed [31:0] in_slope;
    logic signed [31:0] out_slope;
    logic [15:0]        in_scale;
    logic [15:0]        out_scale;
  } kfe_entry_t;

  function automatic logic signed [WIDE_W-1:0] ext36(input logic signed [31:0] v);
    ext36 = {{(WIDE_W-32){v[31]}}, v};
  endfunction

  function automatic logic signed [MUL_A_W-1:0] ext52(input logic signed [WIDE_W-1:0] v);
    ext52 = {{(MUL_A_W-WIDE_W){v[WIDE_W-1]}}, v};
  endfunction

  function automatic logic signed [MUL_B_W-1:0] weight(input logic [15:0] w);
    logic [15:0] ws;
    ws = (w > SCALE_ONE) ? SCALE_ONE : w;
    weight = {{(MUL_B_W-16){1'b0}}, ws};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [MUL_P_W-1:0] v);
    if (v > 88'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -88'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

[design/kfe_ram.sv]
`timescale 1ns / 1ps

module kfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/kfe_mul.sv]
`timescale 1ns / 1ps

module kfe_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 clear,
  input  logic signed [kfe_pkg::MUL_A_W-1:0]   a,
  input  logic signed [kfe_pkg::MUL_B_W-1:0]   b,
  output logic                                 done,
  output logic signed [kfe_pkg::MUL_P_W-1:0]   acc
);
  import kfe_pkg::*;

  // Multiply-accumulate, one 4-bit digit of b per cycle, top digit signed.
  logic                          busy;
  logic [MUL_CNT_W-1:0]          cnt;
  logic signed [MUL_P_W-1:0]     a_sh;
  logic [MUL_B_W-1:0]            b_sh;
  logic                          last;
  logic signed [MUL_DIGIT_W:0]   digit;
  logic signed [MUL_P_W-1:0]     pp;

  always_comb begin
    last  = (cnt == MUL_CNT_W'(MUL_DIGITS - 1));
    digit = {last ? b_sh[MUL_DIGIT_W-1] : 1'b0, b_sh[MUL_DIGIT_W-1:0]};
    pp    = a_sh * digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_sh <= {{(MUL_P_W-MUL_A_W){a[MUL_A_W-1]}}, a};
        b_sh <= b;
        if (clear) begin
          acc <= '0;
        end
      end else if (busy) begin
        acc  <= acc + pp;
        a_sh <= a_sh <<< MUL_DIGIT_W;
        b_sh <= b_sh >> MUL_DIGIT_W;
        cnt  <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/kfe_div.sv]
`timescale 1ns / 1ps

module kfe_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [kfe_pkg::REM_W-1:0]         rem0,
  input  logic [kfe_pkg::DIV_W-1:0]         num,
  input  logic [kfe_pkg::DIV_W-1:0]         den,
  input  logic [kfe_pkg::DIV_CNT_W-1:0]     iter,
  output logic                              done,
  output logic [kfe_pkg::DIV_W-1:0]         quo,
  output logic [kfe_pkg::REM_W-1:0]         rem
);
  import kfe_pkg::*;

  // Restoring division; the numerator bits are shifted in from the top.
  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]      num_sh;
  logic [DIV_W-1:0]      den_r;
  logic [REM_W-1:0]      r2;
  logic                  ge;

  always_comb begin
    r2 = {rem[REM_W-2:0], num_sh[DIV_W-1]};
    ge = (r2 >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= iter;
        rem    <= rem0;
        num_sh <= num;
        den_r  <= den;
        quo    <= '0;
      end else if (busy) begin
        rem    <= ge ? r2 - {1'b0, den_r} : r2;
        quo    <= {quo[DIV_W-2:0], ge};
        num_sh <= num_sh << 1;
        cnt    <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/keyframe_curve_evaluator.sv]
`timescale 1ns / 1ps

// Keyframe curve evaluator. A write item (cmd 0) stores one keyframe in a 16-entry
// table held in a single synchronous RAM and causes no result.
// An evaluate item (cmd 1) returns one result: the curve value at query_time after
// wrapping (clamp, loop or ping-pong), with step, linear or weighted cubic Hermite
// interpolation, and the index of the key that starts the segment used. The block
// works on one evaluate item at a time and stalls its input meanwhile. The cost is
// set by the single-port table reads and by one shared sequential multiplier and
// one shared restoring divider: the table reads, then a divider pass for loop or
// ping-pong wrapping, then the segment search over the keys visited, then a divider
// pass to form t, then one multiplier pass for a linear result or ten multiplier
// passes for a Hermite result.
// A finished result sits in an output register, so the next item is accepted while
// it waits to be taken. Configuration registers: wrap_mode at byte 0, interp_mode
// at byte 4 and key_count at byte 8; key_count values above 16 act as 16. Reading
// a key slot that was never written gives an undefined result.
module keyframe_curve_evaluator (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [3:0]          key_index,
  input  logic signed [31:0]  key_time,
  input  logic signed [31:0]  key_value,
  input  logic signed [31:0]  in_slope,
  input  logic signed [31:0]  out_slope,
  input  logic [15:0]         in_scale,
  input  logic [15:0]         out_scale,
  input  logic signed [31:0]  query_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  curve_value,
  output logic [3:0]          segment_index
);
  import kfe_pkg::*;

  // Configuration registers.
  kfe_wrap_t       wrap_mode;
  kfe_interp_t     interp_mode;
  logic [4:0]      key_count;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_mode   <= WRAP_CLAMP;
      interp_mode <= INTERP_LINEAR;
      key_count   <= '0;
    end else if (cfg_write) begin
      unique case (kfe_reg_t'(paddr[3:2]))
        REG_WRAP_MODE:   wrap_mode   <= kfe_wrap_t'(pwdata[1:0]);
        REG_INTERP_MODE: interp_mode <= kfe_interp_t'(pwdata[1:0]);
        REG_KEY_COUNT:   key_count   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (kfe_reg_t'(paddr[3:2]))
      REG_WRAP_MODE:   prdata = {30'd0, wrap_mode};
      REG_INTERP_MODE: prdata = {30'd0, interp_mode};
      REG_KEY_COUNT:   prdata = {27'd0, key_count};
      default:         prdata = '0;
    endcase
  end

  // Effective number of keys and the index of the last one.
  logic [COUNT_W-1:0]   key_n;
  logic [KEY_IDX_W-1:0] last_idx;

  always_comb begin
    key_n    = (key_count > COUNT_W'(MAX_KEYS)) ? COUNT_W'(MAX_KEYS) : key_count;
    last_idx = KEY_IDX_W'(key_n - 1'b1);
  end

  // Keyframe table.
  kfe_state_t           state;
  kfe_state_t           state_next;
  logic                 in_acc;
  logic                 ram_we;
  logic [KEY_IDX_W-1:0] raddr;
  kfe_entry_t           wentry;
  kfe_entry_t           rentry;
  logic [$bits(kfe_entry_t)-1:0] rdata;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ram_we   = in_acc && (cmd == CMD_WRITE);
  assign rentry   = kfe_entry_t'(rdata);

  always_comb begin
    wentry.key_time  = key_time;
    wentry.key_value = key_value;
    wentry.in_slope  = in_slope;
    wentry.out_slope = out_slope;
    wentry.in_scale  = in_scale;
    wentry.out_scale = out_scale;
  end

  kfe_ram #(
    .WIDTH ($bits(kfe_entry_t)),
    .DEPTH (MAX_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_index),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Item working registers. ea is the key at the segment start, eb the key at its end.
  logic signed [31:0]        q_reg;
  kfe_entry_t                ea;
  kfe_entry_t                eb;
  logic signed [31:0]        end_time;
  logic signed [31:0]        end_value;
  logic signed [WIDE_W-1:0]  ev;
  logic [KEY_IDX_W-1:0]      idx;
  logic signed [WIDE_W-1:0]  span_reg;
  logic [T_W-1:0]            t_reg;
  logic [T_W-1:0]            t2_reg;
  logic [T_W-1:0]            t3_reg;
  logic signed [47:0]        p_reg;
  logic signed [MUL_A_W-1:0] m0_reg;
  logic signed [MUL_A_W-1:0] m1_reg;
  logic signed [31:0]        res_value;
  logic [KEY_IDX_W-1:0]      res_seg;
  logic                      out_load;

  // Shared arithmetic units.
  logic                       mul_start;
  logic                       mul_clear;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic                       mul_done;
  logic signed [MUL_P_W-1:0]  mul_acc;
  logic                       mul_launched;
  logic                       mul_state;

  logic                       div_start;
  logic [REM_W-1:0]           div_rem0;
  logic [DIV_W-1:0]           div_num;
  logic [DIV_W-1:0]           div_den;
  logic [DIV_CNT_W-1:0]       div_iter;
  logic                       div_done;
  logic [DIV_W-1:0]           div_quo;
  logic [REM_W-1:0]           div_rem;

  kfe_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .clear (mul_clear),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .acc   (mul_acc)
  );

  kfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .rem0  (div_rem0),
    .num   (div_num),
    .den   (div_den),
    .iter  (div_iter),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Wrap arithmetic. The first key stays in ea until the segment search starts.
  logic signed [WIDE_W-1:0] start36;
  logic signed [WIDE_W-1:0] end36;
  logic signed [WIDE_W-1:0] dur_raw;
  logic signed [WIDE_W-1:0] dur;
  logic signed [WIDE_W-1:0] wrap_den;
  logic signed [WIDE_W-1:0] wrap_a;
  logic signed [WIDE_W-1:0] abs_a;
  logic signed [WIDE_W-1:0] rem36;
  logic signed [WIDE_W-1:0] rr;
  logic signed [WIDE_W-1:0] ev_wrap;
  logic                     do_wrap;

  always_comb begin
    start36  = ext36(ea.key_time);
    end36    = ext36(end_time);
    dur_raw  = end36 - start36;
    dur      = (dur_raw < 36'sd1) ? 36'sd1 : dur_raw;
    wrap_den = (wrap_mode == WRAP_PING) ? (dur <<< 1) : dur;
    wrap_a   = ext36(q_reg) - start36;
    abs_a    = (wrap_a < 0) ? -wrap_a : wrap_a;
    do_wrap  = (wrap_mode == WRAP_LOOP) || (wrap_mode == WRAP_PING);
    rem36    = {1'b0, div_rem};
    // Floor modulo: a negative remainder folds back into [0, modulus).
    rr       = ((wrap_a < 0) && (rem36 != 0)) ? wrap_den - rem36 : rem36;
    if (wrap_mode == WRAP_PING && rr > dur) begin
      ev_wrap = end36 - (rr - dur);
    end else begin
      ev_wrap = start36 + rr;
    end
  end

  // Segment test against the key just read.
  logic signed [WIDE_W-1:0] ta;
  logic signed [WIDE_W-1:0] tb;
  logic signed [WIDE_W-1:0] span_raw;
  logic signed [WIDE_W-1:0] span;
  logic signed [WIDE_W-1:0] t_off;
  logic                     past_key;
  logic                     t_zero;
  logic                     t_full;

  always_comb begin
    ta       = ext36(ea.key_time);
    tb       = ext36(rentry.key_time);
    span_raw = tb - ta;
    span     = (span_raw < 36'sd1) ? 36'sd1 : span_raw;
    t_off    = ev - ta;
    past_key = (ev > tb);
    t_zero   = (t_off <= 0);
    t_full   = (t_off >= span);
  end

  // Hermite basis in Q16 from t, t^2 and t^3.
  logic signed [WIDE_W-1:0] t36;
  logic signed [WIDE_W-1:0] t2_36;
  logic signed [WIDE_W-1:0] t3_36;
  logic signed [WIDE_W-1:0] h00;
  logic signed [WIDE_W-1:0] h10;
  logic signed [WIDE_W-1:0] h01;
  logic signed [WIDE_W-1:0] h11;

  always_comb begin
    t36   = {{(WIDE_W-T_W){1'b0}}, t_reg};
    t2_36 = {{(WIDE_W-T_W){1'b0}}, t2_reg};
    t3_36 = {{(WIDE_W-T_W){1'b0}}, t3_reg};
    h00   = (t3_36 <<< 1) - 3 * t2_36 + ext36(32'sd65536);
    h10   = t3_36 - (t2_36 <<< 1) + t36;
    h01   = 3 * t2_36 - (t3_36 <<< 1);
    h11   = t3_36 - t2_36;
  end

  logic signed [MUL_P_W-1:0] rnd16;
  logic signed [MUL_P_W-1:0] rnd31;
  logic signed [MUL_P_W-1:0] lin_sum;

  always_comb begin
    rnd16   = (mul_acc + HALF_Q16) >>> 16;
    rnd31   = (mul_acc + HALF_Q31) >>> 31;
    lin_sum = {{(MUL_P_W-32){ea.key_value[31]}}, ea.key_value} + rnd16;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_EVAL) begin
          state_next = (key_n == '0) ? ST_FIN : ST_RD0;
        end
      end
      ST_RD0:  state_next = ST_RDL;
      ST_RDL:  state_next = (key_n == COUNT_W'(1)) ? ST_FIN : ST_RDE;
      ST_RDE:  state_next = ST_WRAP;
      ST_WRAP: state_next = do_wrap ? ST_MOD : ST_CMP;
      ST_MOD:  state_next = div_done ? ST_CMP : ST_MOD;
      ST_CMP: begin
        if (ev <= start36 || ev >= end36) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_SRD;
        end
      end
      ST_SRD:  state_next = ST_SCHK;
      ST_SCHK: begin
        if (past_key) begin
          state_next = (idx == last_idx) ? ST_FIN : ST_SRD;
        end else if (interp_mode == INTERP_STEP) begin
          state_next = ST_FIN;
        end else if (!t_zero && !t_full) begin
          state_next = ST_TDIV;
        end else begin
          state_next = (interp_mode == INTERP_LINEAR) ? ST_LIN : ST_T2;
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          state_next = (interp_mode == INTERP_LINEAR) ? ST_LIN : ST_T2;
        end
      end
      ST_LIN:  state_next = mul_done ? ST_FIN : ST_LIN;
      ST_T2:   state_next = mul_done ? ST_T3 : ST_T2;
      ST_T3:   state_next = mul_done ? ST_P0 : ST_T3;
      ST_P0:   state_next = mul_done ? ST_M0 : ST_P0;
      ST_M0:   state_next = mul_done ? ST_P1 : ST_M0;
      ST_P1:   state_next = mul_done ? ST_M1 : ST_P1;
      ST_M1:   state_next = mul_done ? ST_S0 : ST_M1;
      ST_S0:   state_next = mul_done ? ST_S1 : ST_S0;
      ST_S1:   state_next = mul_done ? ST_S2 : ST_S1;
      ST_S2:   state_next = mul_done ? ST_S3 : ST_S2;
      ST_S3:   state_next = mul_done ? ST_FIN : ST_S3;
      ST_FIN:  state_next = (!out_valid || !out_stall) ? ST_IDLE : ST_FIN;
      default: state_next = ST_IDLE;
    endcase
  end

  // Output logic: table address and operands of the shared units.
  always_comb begin
    raddr     = '0;
    mul_state = 1'b0;
    mul_clear = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_rem0  = '0;
    div_num   = '0;
    div_den   = '0;
    div_iter  = '0;
    unique case (state)
      ST_RDL: raddr = last_idx;
      ST_SRD: raddr = idx;
      ST_WRAP: begin
        div_start = do_wrap;
        div_num   = abs_a[DIV_W-1:0];
        div_den   = wrap_den[DIV_W-1:0];
        div_iter  = DIV_CNT_W'(DIV_W);
      end
      ST_SCHK: begin
        // The quotient (t_off << 16) / span fits in 16 bits since t_off < span.
        div_start = !past_key && (interp_mode != INTERP_STEP) && !t_zero && !t_full;
        div_rem0  = t_off[REM_W-1:0];
        div_den   = span[DIV_W-1:0];
        div_iter  = DIV_CNT_W'(T_BITS);
      end
      ST_LIN: begin
        mul_state = 1'b1;
        mul_a     = ext52(ext36(eb.key_value) - ext36(ea.key_value));
        mul_b     = t36;
      end
      ST_T2: begin
        mul_state = 1'b1;
        mul_a     = ext52(t36);
        mul_b     = t36;
      end
      ST_T3: begin
        mul_state = 1'b1;
        mul_a     = ext52(t2_36);
        mul_b     = t36;
      end
      ST_P0: begin
        mul_state = 1'b1;
        mul_a     = ext52(ext36(ea.out_slope));
        mul_b     = weight(ea.out_scale);
      end
      ST_M0, ST_M1: begin
        mul_state = 1'b1;
        mul_a     = {{(MUL_A_W-48){p_reg[47]}}, p_reg};
        mul_b     = span_reg;
      end
      ST_P1: begin
        mul_state = 1'b1;
        mul_a     = ext52(ext36(eb.in_slope));
        mul_b     = weight(eb.in_scale);
      end
      ST_S0: begin
        mul_state = 1'b1;
        mul_a     = ext52(ext36(ea.key_value));
        mul_b     = h00;
      end
      ST_S1: begin
        mul_state = 1'b1;
        mul_clear = 1'b0;
        mul_a     = m0_reg;
        mul_b     = h10;
      end
      ST_S2: begin
        mul_state = 1'b1;
        mul_clear = 1'b0;
        mul_a     = ext52(ext36(eb.key_value));
        mul_b     = h01;
      end
      ST_S3: begin
        mul_state = 1'b1;
        mul_clear = 1'b0;
        mul_a     = m1_reg;
        mul_b     = h11;
      end
      default: ;
    endcase
  end

  // Each multiply state launches the multiplier once and waits for it.
  assign mul_start = mul_state && !mul_launched;
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mul_launched <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start) begin
        mul_launched <= 1'b1;
      end else if (mul_done) begin
        mul_launched <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        q_reg     <= query_time;
        res_value <= '0;
        res_seg   <= '0;
      end
      ST_RDL: begin
        ea        <= rentry;
        res_value <= rentry.key_value;
        res_seg   <= '0;
      end
      ST_RDE: begin
        end_time  <= rentry.key_time;
        end_value <= rentry.key_value;
      end
      ST_WRAP: ev <= ext36(q_reg);
      ST_MOD: begin
        if (div_done) begin
          ev <= ev_wrap;
        end
      end
      ST_CMP: begin
        idx <= KEY_IDX_W'(1);
        if (ev <= start36) begin
          res_value <= ea.key_value;
          res_seg   <= '0;
        end else begin
          res_value <= end_value;
          res_seg   <= last_idx;
        end
      end
      ST_SCHK: begin
        if (past_key) begin
          // Also the result when no segment is found in an unsorted table.
          ea        <= rentry;
          idx       <= idx + 1'b1;
          res_value <= end_value;
          res_seg   <= last_idx;
        end else begin
          eb        <= rentry;
          span_reg  <= span;
          res_seg   <= idx - 1'b1;
          res_value <= ea.key_value;
          t_reg     <= t_full ? T_ONE : '0;
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          t_reg <= div_quo[T_W-1:0];
        end
      end
      ST_LIN: begin
        if (mul_done) begin
          res_value <= sat32(lin_sum);
        end
      end
      ST_T2: begin
        if (mul_done) begin
          t2_reg <= rnd16[T_W-1:0];
        end
      end
      ST_T3: begin
        if (mul_done) begin
          t3_reg <= rnd16[T_W-1:0];
        end
      end
      ST_P0, ST_P1: begin
        if (mul_done) begin
          p_reg <= mul_acc[47:0];
        end
      end
      ST_M0: begin
        if (mul_done) begin
          m0_reg <= rnd31[MUL_A_W-1:0];
        end
      end
      ST_M1: begin
        if (mul_done) begin
          m1_reg <= rnd31[MUL_A_W-1:0];
        end
      end
      ST_S3: begin
        if (mul_done) begin
          res_value <= sat32(rnd16);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      curve_value   <= res_value;
      segment_index <= res_seg;
    end
  end

  // An accepted evaluate item holds the input side until its result is formed.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == CMD_EVAL |=> in_stall)
    else $error("evaluate item did not occupy the block");

  // A finished result waits while the output register is still occupied.
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_valid && out_stall |=> state == ST_FIN)
    else $error("result left before the output register was free");

  // The reported segment starts at a valid key, or is zero when the table is empty.
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> (key_n == '0 && res_seg == '0) || ({1'b0, res_seg} < key_n))
    else $error("segment index beyond the key count");

  // The multiplier is only running while a multiply state owns it.
  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_launched |-> mul_state)
    else $error("multiplier running outside a multiply state");

endmodule
